// ===== rtl/core/osa_pkg.sv =====
`timescale 1ns / 1ps

package osa_pkg;

    localparam int STACK_DEPTH = 1024;
    localparam int WORD_BITS   = 32;
    localparam int ADDR_W      = $clog2(STACK_DEPTH);
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    localparam int MODE_BITS   = 3;
    localparam int IN_BITS     = 32;
    localparam int INDEX_BITS  = 10;
    localparam int OUT_BITS    = 32;
    localparam int STATUS_BITS = 3;
    localparam int DEPTH_BITS  = 11;

    typedef logic [WORD_BITS-1:0] word_t;
    typedef logic [ADDR_W-1:0]    addr_t;
    typedef logic [CNT_W-1:0]     count_t;

    typedef enum logic [MODE_BITS-1:0] {
        MODE_PUSH     = 3'd0,
        MODE_POP      = 3'd1,
        MODE_PEEK_TOP = 3'd2,
        MODE_PEEK_BOT = 3'd3,
        MODE_ADD      = 3'd4,
        MODE_SUB      = 3'd5,
        MODE_MUL      = 3'd6,
        MODE_DIV      = 3'd7
    } mode_t;

    typedef enum logic [STATUS_BITS-1:0] {
        ST_OK        = 3'd0,
        ST_EMPTY     = 3'd1,
        ST_RANGE     = 3'd2,
        ST_FEW       = 3'd3,
        ST_FULL      = 3'd4,
        ST_DIV_ZERO  = 3'd5
    } status_t;

    typedef enum logic [2:0] {
        K_PUSH,
        K_POP,
        K_PEEK_TOP,
        K_PEEK_BOT,
        K_ARITH
    } kind_t;

    typedef enum logic [1:0] {
        ALU_ADD,
        ALU_SUB,
        ALU_MUL,
        ALU_DIV
    } alu_t;

    typedef struct packed {
        kind_t                 kind;
        alu_t                  alu;
        word_t                 word;
        logic [INDEX_BITS-1:0] index;
    } item_t;

    typedef struct packed {
        logic  avail;
        item_t item;
    } head_t;

endpackage

// ===== rtl/core/operand_stack_alu_core.sv =====
`timescale 1ns / 1ps

// channel   handshake            payload
// -------   ------------------   ---------------------------
// command   start in, busy out   mode, push_value, index
// result    done out (strobe)    value, status, depth
//
// a command goes into a two-entry queue; the execute side takes one entry,
// reads the top entries of the stack ram in S_IDLE and finishes in S_EXEC;
// divide goes on in S_DIV while the bit-serial divider runs. reset empties
// the queue and the stack count; ram contents are not cleared. busy is high
// while the queue is full; each result is shown for one cycle with done high
// and cannot be held off.

module operand_stack_alu_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [osa_pkg::MODE_BITS-1:0]      mode,
    input  logic signed [osa_pkg::IN_BITS-1:0] push_value,
    input  logic [osa_pkg::INDEX_BITS-1:0]     index,
    output logic                               done,
    output logic signed [osa_pkg::OUT_BITS-1:0] value,
    output logic [osa_pkg::STATUS_BITS-1:0]    status,
    output logic [osa_pkg::DEPTH_BITS-1:0]     depth
);

    import osa_pkg::*;

    head_t  head;
    logic   pop;
    logic   we;
    addr_t  waddr;
    word_t  wdata;
    addr_t  raddr0;
    addr_t  raddr1;
    word_t  rdata0;
    word_t  rdata1;

    osa_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .mode       (mode),
        .push_value (push_value),
        .index      (index),
        .busy       (busy),
        .pop        (pop),
        .head       (head)
    );

    osa_back u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .head   (head),
        .pop    (pop),
        .we     (we),
        .waddr  (waddr),
        .wdata  (wdata),
        .raddr0 (raddr0),
        .raddr1 (raddr1),
        .rdata0 (rdata0),
        .rdata1 (rdata1),
        .done   (done),
        .value  (value),
        .status (status),
        .depth  (depth)
    );

    osa_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (STACK_DEPTH)
    ) u_ram (
        .clk    (clk),
        .we     (we),
        .waddr  (waddr),
        .wdata  (wdata),
        .raddr0 (raddr0),
        .raddr1 (raddr1),
        .rdata0 (rdata0),
        .rdata1 (rdata1)
    );

endmodule

// ===== rtl/core/osa_ram.sv =====
`timescale 1ns / 1ps

module osa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [WIDTH-1:0]         rdata0,
    output logic [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule

// ===== rtl/core/osa_div.sv =====
`timescale 1ns / 1ps

module osa_div (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  osa_pkg::word_t num,
    input  osa_pkg::word_t den,
    output logic          done,
    output osa_pkg::word_t quo
);

    import osa_pkg::*;

    localparam int STEP_W = $clog2(WORD_BITS);

    typedef enum logic [1:0] {
        D_IDLE,
        D_RUN,
        D_FIX
    } dstate_t;

    dstate_t             state_reg;
    logic [STEP_W-1:0]   step_reg;
    word_t               q_reg;
    word_t               rem_reg;
    word_t               den_reg;
    logic                neg_reg;
    logic                done_reg;
    word_t               out_reg;

    logic [WORD_BITS:0]  shifted;
    logic [WORD_BITS:0]  diff;

    assign shifted = {rem_reg, q_reg[WORD_BITS-1]};
    assign diff    = shifted - {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                D_IDLE:
                begin
                    if (start)
                    begin
                        // work on magnitudes, fix the sign at the end
                        q_reg     <= num[WORD_BITS-1] ? (~num + 1'b1) : num;
                        den_reg   <= den[WORD_BITS-1] ? (~den + 1'b1) : den;
                        neg_reg   <= num[WORD_BITS-1] ^ den[WORD_BITS-1];
                        rem_reg   <= '0;
                        step_reg  <= '0;
                        state_reg <= D_RUN;
                    end
                end
                D_RUN:
                begin
                    if (!diff[WORD_BITS])
                    begin
                        rem_reg <= diff[WORD_BITS-1:0];
                        q_reg   <= {q_reg[WORD_BITS-2:0], 1'b1};
                    end
                    else
                    begin
                        rem_reg <= shifted[WORD_BITS-1:0];
                        q_reg   <= {q_reg[WORD_BITS-2:0], 1'b0};
                    end
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == STEP_W'(WORD_BITS - 1))
                    begin
                        state_reg <= D_FIX;
                    end
                end
                D_FIX:
                begin
                    // floor: round away from zero when signs differ and inexact
                    if (neg_reg)
                    begin
                        out_reg <= ~(q_reg + word_t'(rem_reg != '0)) + 1'b1;
                    end
                    else
                    begin
                        out_reg <= q_reg;
                    end
                    done_reg  <= 1'b1;
                    state_reg <= D_IDLE;
                end
                default:
                begin
                    state_reg <= D_IDLE;
                end
            endcase
        end
    end

    assign done = done_reg;
    assign quo  = out_reg;

endmodule

// ===== rtl/core/osa_front.sv =====
`timescale 1ns / 1ps

module osa_front (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic [osa_pkg::MODE_BITS-1:0]      mode,
    input  logic signed [osa_pkg::IN_BITS-1:0] push_value,
    input  logic [osa_pkg::INDEX_BITS-1:0]     index,
    output logic                               busy,
    input  logic                               pop,
    output osa_pkg::head_t                     head
);

    import osa_pkg::*;

    item_t      entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] fill_reg;
    item_t      decoded;
    logic       push;
    logic       take;

    always_comb
    begin
        decoded.kind  = K_PUSH;
        decoded.alu   = ALU_ADD;
        decoded.word  = WORD_BITS'(push_value);
        decoded.index = index;
        unique case (mode_t'(mode))
            MODE_PUSH:     decoded.kind = K_PUSH;
            MODE_POP:      decoded.kind = K_POP;
            MODE_PEEK_TOP: decoded.kind = K_PEEK_TOP;
            MODE_PEEK_BOT: decoded.kind = K_PEEK_BOT;
            MODE_ADD:
            begin
                decoded.kind = K_ARITH;
                decoded.alu  = ALU_ADD;
            end
            MODE_SUB:
            begin
                decoded.kind = K_ARITH;
                decoded.alu  = ALU_SUB;
            end
            MODE_MUL:
            begin
                decoded.kind = K_ARITH;
                decoded.alu  = ALU_MUL;
            end
            MODE_DIV:
            begin
                decoded.kind = K_ARITH;
                decoded.alu  = ALU_DIV;
            end
        endcase
    end

    assign busy = (fill_reg == 2'd2);
    assign push = start && !busy;
    assign take = pop && (fill_reg != 2'd0);

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= decoded;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (take)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            fill_reg <= fill_reg + {1'b0, push} - {1'b0, take};
        end
    end

    assign head.avail = (fill_reg != 2'd0);
    assign head.item  = entry_reg[rd_ptr_reg];

endmodule

// ===== rtl/core/osa_back.sv =====
`timescale 1ns / 1ps

module osa_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  osa_pkg::head_t                      head,
    output logic                                pop,
    output logic                                we,
    output osa_pkg::addr_t                      waddr,
    output osa_pkg::word_t                      wdata,
    output osa_pkg::addr_t                      raddr0,
    output osa_pkg::addr_t                      raddr1,
    input  osa_pkg::word_t                      rdata0,
    input  osa_pkg::word_t                      rdata1,
    output logic                                done,
    output logic signed [osa_pkg::OUT_BITS-1:0] value,
    output logic [osa_pkg::STATUS_BITS-1:0]     status,
    output logic [osa_pkg::DEPTH_BITS-1:0]      depth
);

    import osa_pkg::*;

    localparam int EXT_W = ((CNT_W > INDEX_BITS) ? CNT_W : INDEX_BITS) + 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_DIV
    } bstate_t;

    bstate_t        state_reg;
    item_t          op_reg;
    status_t        err_reg;
    addr_t          waddr_reg;
    count_t         count_reg;
    logic           done_reg;
    word_t          value_reg;
    status_t        status_reg;
    count_t         depth_reg;

    logic [EXT_W-1:0] cnt_x;
    logic [EXT_W-1:0] idx_x;
    addr_t          top_addr;
    addr_t          second_addr;
    status_t        check;
    word_t          alu_r;
    logic           div_start;
    logic           div_done;
    word_t          div_q;

    assign cnt_x       = EXT_W'(count_reg);
    assign idx_x       = EXT_W'(head.item.index);
    assign top_addr    = ADDR_W'(count_reg - count_t'(1));
    assign second_addr = ADDR_W'(count_reg - count_t'(2));

    // error checks against the count before this item
    always_comb
    begin
        check  = ST_OK;
        raddr0 = top_addr;
        unique case (head.item.kind)
            K_PUSH:
            begin
                if (count_reg == count_t'(STACK_DEPTH))
                begin
                    check = ST_FULL;
                end
            end
            K_POP:
            begin
                if (count_reg == '0)
                begin
                    check = ST_EMPTY;
                end
            end
            K_PEEK_TOP:
            begin
                raddr0 = ADDR_W'(cnt_x - EXT_W'(1) - idx_x);
                if (idx_x >= cnt_x)
                begin
                    check = ST_RANGE;
                end
            end
            K_PEEK_BOT:
            begin
                raddr0 = ADDR_W'(idx_x);
                if (idx_x >= cnt_x)
                begin
                    check = ST_RANGE;
                end
            end
            K_ARITH:
            begin
                if (count_reg < count_t'(2))
                begin
                    check = ST_FEW;
                end
            end
            default:
            begin
                check = ST_OK;
            end
        endcase
    end

    assign raddr1 = second_addr;
    assign pop    = (state_reg == S_IDLE) && head.avail;

    // rdata0 is the top entry (a), rdata1 the second (b)
    always_comb
    begin
        unique case (op_reg.alu)
            ALU_ADD: alu_r = rdata1 + rdata0;
            ALU_SUB: alu_r = rdata1 - rdata0;
            ALU_MUL: alu_r = word_t'(rdata1 * rdata0);
            ALU_DIV: alu_r = '0;
        endcase
    end

    assign div_start = (state_reg == S_EXEC) && (err_reg == ST_OK)
                       && (op_reg.kind == K_ARITH) && (op_reg.alu == ALU_DIV)
                       && (rdata0 != '0);

    always_comb
    begin
        we    = 1'b0;
        wdata = alu_r;
        if (state_reg == S_EXEC && err_reg == ST_OK)
        begin
            if (op_reg.kind == K_PUSH)
            begin
                we    = 1'b1;
                wdata = op_reg.word;
            end
            else if (op_reg.kind == K_ARITH && op_reg.alu != ALU_DIV)
            begin
                we = 1'b1;
            end
        end
        else if (state_reg == S_DIV && div_done)
        begin
            we    = 1'b1;
            wdata = div_q;
        end
    end

    assign waddr = waddr_reg;

    osa_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (rdata1),
        .den   (rdata0),
        .done  (div_done),
        .quo   (div_q)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE:
                begin
                    if (head.avail)
                    begin
                        op_reg    <= head.item;
                        err_reg   <= check;
                        waddr_reg <= (head.item.kind == K_PUSH) ? ADDR_W'(count_reg)
                                                                : second_addr;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    state_reg  <= S_IDLE;
                    done_reg   <= 1'b1;
                    value_reg  <= '0;
                    status_reg <= err_reg;
                    depth_reg  <= count_reg;
                    if (err_reg == ST_OK)
                    begin
                        unique case (op_reg.kind)
                            K_PUSH:
                            begin
                                count_reg <= count_reg + 1'b1;
                                depth_reg <= count_reg + 1'b1;
                            end
                            K_POP:
                            begin
                                value_reg <= rdata0;
                                count_reg <= count_reg - 1'b1;
                                depth_reg <= count_reg - 1'b1;
                            end
                            K_PEEK_TOP, K_PEEK_BOT:
                            begin
                                value_reg <= rdata0;
                            end
                            K_ARITH:
                            begin
                                if (op_reg.alu != ALU_DIV)
                                begin
                                    value_reg <= alu_r;
                                    count_reg <= count_reg - 1'b1;
                                    depth_reg <= count_reg - 1'b1;
                                end
                                else if (rdata0 == '0)
                                begin
                                    status_reg <= ST_DIV_ZERO;
                                end
                                else
                                begin
                                    done_reg  <= 1'b0;
                                    state_reg <= S_DIV;
                                end
                            end
                            default:
                            begin
                                value_reg <= '0;
                            end
                        endcase
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        done_reg   <= 1'b1;
                        value_reg  <= div_q;
                        status_reg <= ST_OK;
                        count_reg  <= count_reg - 1'b1;
                        depth_reg  <= count_reg - 1'b1;
                        state_reg  <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign done   = done_reg;
    assign value  = OUT_BITS'($signed(value_reg));
    assign status = status_reg;
    assign depth  = DEPTH_BITS'(depth_reg);

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import osa_pkg::*;

    localparam int PLAN  = 0;
    localparam int CHECK = 1;

    typedef struct packed {
        logic                  drain;
        logic                  quiet;
        mode_t                 op;
        logic signed [31:0]    operand;
        logic [INDEX_BITS-1:0] idx;
    } cmd_t;

    typedef struct packed {
        word_t                 value;
        status_t               status;
        logic [DEPTH_BITS-1:0] depth;
    } stack_result_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          start = 1'b0;
    logic                          busy;
    logic [MODE_BITS-1:0]          mode = '0;
    logic signed [IN_BITS-1:0]     push_value = '0;
    logic [INDEX_BITS-1:0]         index = '0;
    logic                          done;
    logic signed [OUT_BITS-1:0]    value;
    logic [STATUS_BITS-1:0]        status;
    logic [DEPTH_BITS-1:0]         depth;

    // two copies of the stack: one steers the generator, one predicts results
    word_t         shadow_mem [2][STACK_DEPTH];
    int unsigned   shadow_cnt [2] = '{0, 0};

    cmd_t          feed_q [$];
    stack_result_t expected_q [$];
    int unsigned   n_sent = 0;
    int unsigned   n_got = 0;
    int unsigned   idle_left = 0;
    int unsigned   err_cnt = 0;
    int unsigned   peak_depth = 0;
    int unsigned   status_seen [6] = '{0, 0, 0, 0, 0, 0};
    logic          quiet_tail = 1'b0;

    operand_stack_alu_core i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .mode       (mode),
        .push_value (push_value),
        .index      (index),
        .done       (done),
        .value      (value),
        .status     (status),
        .depth      (depth)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic stack_result_t step_stack(input int sel, input cmd_t c);
        stack_result_t res;
        word_t         a;
        word_t         b;
        word_t         r;
        int unsigned   n;
        longint        num;
        longint        den;
        longint        quo;
        longint        rem;
        res.value  = '0;
        res.status = ST_OK;
        r = '0;
        n = shadow_cnt[sel];
        case (c.op)
            MODE_PUSH:
                if (n >= STACK_DEPTH)
                    res.status = ST_FULL;
                else
                begin
                    shadow_mem[sel][n] = c.operand;
                    n++;
                end
            MODE_POP:
                if (n == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    n--;
                    res.value = shadow_mem[sel][n];
                end
            MODE_PEEK_TOP:
                if (c.idx >= n)
                    res.status = ST_RANGE;
                else
                    res.value = shadow_mem[sel][n - 1 - c.idx];
            MODE_PEEK_BOT:
                if (c.idx >= n)
                    res.status = ST_RANGE;
                else
                    res.value = shadow_mem[sel][c.idx];
            default:
                if (n < 2)
                    res.status = ST_FEW;
                else
                begin
                    a = shadow_mem[sel][n - 1];
                    b = shadow_mem[sel][n - 2];
                    case (c.op)
                        MODE_ADD: r = b + a;
                        MODE_SUB: r = b - a;
                        MODE_MUL: r = b * a;
                        default:
                            if (a == '0)
                                res.status = ST_DIV_ZERO;
                            else
                            begin
                                // floor division: truncating quotient moved down when
                                // the remainder and divisor differ in sign
                                num = $signed(b);
                                den = $signed(a);
                                quo = num / den;
                                rem = num % den;
                                if (rem != 0 && ((rem < 0) != (den < 0)))
                                    quo = quo - 1;
                                r = quo[WORD_BITS-1:0];
                            end
                    endcase
                    if (res.status == ST_OK)
                    begin
                        shadow_mem[sel][n - 2] = r;
                        n--;
                        res.value = r;
                    end
                end
        endcase
        shadow_cnt[sel] = n;
        res.depth = DEPTH_BITS'(n);
        return res;
    endfunction

    function automatic void queue_cmd(input mode_t op, input logic signed [31:0] operand,
                                      input int unsigned idx);
        cmd_t          c;
        stack_result_t unused;
        c.drain   = 1'b0;
        c.quiet   = quiet_tail;
        c.op      = op;
        c.operand = operand;
        c.idx     = INDEX_BITS'(idx);
        feed_q.push_back(c);
        unused = step_stack(PLAN, c);
    endfunction

    function automatic void queue_drain();
        cmd_t c;
        c = '0;
        c.drain = 1'b1;
        feed_q.push_back(c);
    endfunction

    function automatic logic signed [31:0] pick_word();
        case ($urandom_range(0, 7))
            0: return 32'sd0;
            1: return 32'sh8000_0000;
            2: return 32'sh7fff_ffff;
            3: return -32'sd1;
            4, 5: return $signed($urandom_range(0, 40)) - 20;
            default: return $urandom;
        endcase
    endfunction

    always @(posedge clk)
    begin : drive_cmds
        logic go;
        logic took;
        if (rst_n)
        begin
            go   = start;
            took = 1'b0;
            if (start && !busy)
            begin
                expected_q.push_back(step_stack(CHECK, feed_q[0]));
                if (!feed_q[0].quiet && $urandom_range(0, 5) == 0)
                    idle_left = $urandom_range(1, 17);
                feed_q.pop_front();
                n_sent <= n_sent + 1;
                go   = 1'b0;
                took = 1'b1;
            end
            if (!go)
            begin
                if (idle_left > 0)
                    idle_left--;
                else if (feed_q.size() > 0)
                begin
                    if (feed_q[0].drain)
                    begin
                        // hold off until every outstanding result is back
                        if (!took && n_sent == n_got)
                            feed_q.pop_front();
                    end
                    else
                    begin
                        go = 1'b1;
                        mode       <= feed_q[0].op;
                        push_value <= feed_q[0].operand;
                        index      <= feed_q[0].idx;
                    end
                end
            end
            start <= go;
        end
    end

    always @(posedge clk)
    begin : check_results
        stack_result_t want;
        if (rst_n && done)
        begin
            n_got <= n_got + 1;
            if (depth > peak_depth)
                peak_depth = depth;
            if (status < 6)
                status_seen[status]++;
            if (expected_q.size() == 0)
            begin
                err_cnt++;
                $display("%0t: result with none expected: value %0d status %0d depth %0d",
                         $time, value, status, depth);
            end
            else
            begin
                want = expected_q.pop_front();
                if (value !== want.value)
                begin
                    err_cnt++;
                    $display("%0t: value mismatch: expected %0d actual %0d",
                             $time, $signed(want.value), value);
                end
                if (status !== want.status)
                begin
                    err_cnt++;
                    $display("%0t: status mismatch: expected %0d actual %0d",
                             $time, want.status, status);
                end
                if (depth !== want.depth)
                begin
                    err_cnt++;
                    $display("%0t: depth mismatch: expected %0d actual %0d",
                             $time, want.depth, depth);
                end
            end
        end
    end

    initial
    begin : stimulus
        int    k;
        int    d;
        int    roll;
        mode_t op;

        // directed: errors on an empty stack, extremes and division corners
        queue_cmd(MODE_POP, 0, 0);
        queue_cmd(MODE_PEEK_TOP, 0, 0);
        queue_cmd(MODE_PEEK_BOT, 0, 1023);
        queue_cmd(MODE_ADD, 0, 0);
        queue_cmd(MODE_PUSH, 32'sh8000_0000, 0);
        queue_cmd(MODE_MUL, 0, 0);
        queue_cmd(MODE_PUSH, -1, 0);
        queue_cmd(MODE_DIV, 0, 0);
        queue_cmd(MODE_PUSH, 0, 0);
        queue_cmd(MODE_DIV, 0, 0);
        queue_cmd(MODE_PEEK_TOP, 0, 1);
        queue_cmd(MODE_PEEK_BOT, 0, 1);
        queue_cmd(MODE_PEEK_TOP, 0, 2);
        queue_cmd(MODE_POP, 0, 0);
        queue_cmd(MODE_PUSH, 32'sh7fff_ffff, 0);
        queue_cmd(MODE_ADD, 0, 0);
        queue_cmd(MODE_PUSH, -7, 0);
        queue_cmd(MODE_PUSH, 2, 0);
        queue_cmd(MODE_DIV, 0, 0);
        queue_cmd(MODE_PUSH, 3, 0);
        queue_cmd(MODE_SUB, 0, 0);
        queue_cmd(MODE_PUSH, 32'sh7fff_ffff, 0);
        queue_cmd(MODE_MUL, 0, 0);
        queue_cmd(MODE_PUSH, 0, 0);
        queue_cmd(MODE_PUSH, -5, 0);
        queue_cmd(MODE_DIV, 0, 0);
        queue_cmd(MODE_PUSH, -3, 0);
        queue_cmd(MODE_DIV, 0, 0);
        queue_drain();

        // fill to the top, hit the full case, then unwind
        while (shadow_cnt[PLAN] > 0)
            queue_cmd(MODE_POP, 0, 0);
        while (shadow_cnt[PLAN] < STACK_DEPTH)
            queue_cmd(MODE_PUSH, $urandom, 0);
        queue_cmd(MODE_PUSH, pick_word(), 0);
        queue_cmd(MODE_PUSH, pick_word(), 0);
        queue_cmd(MODE_PEEK_TOP, 0, 1023);
        queue_cmd(MODE_PEEK_BOT, 0, 1023);
        queue_cmd(MODE_PEEK_BOT, 0, 0);
        queue_cmd(MODE_PEEK_TOP, 0, 0);
        queue_cmd(MODE_ADD, 0, 0);
        queue_cmd(MODE_PUSH, pick_word(), 0);
        queue_cmd(MODE_PUSH, pick_word(), 0);
        queue_cmd(MODE_DIV, 0, 0);
        queue_cmd(MODE_MUL, 0, 0);
        queue_cmd(MODE_SUB, 0, 0);
        while (shadow_cnt[PLAN] > 0)
        begin
            if ($urandom_range(0, 15) == 0)
                queue_cmd(mode_t'(MODE_ADD + $urandom_range(0, 3)), 0, 0);
            else
                queue_cmd(MODE_POP, 0, 0);
        end
        queue_cmd(MODE_POP, 0, 0);
        queue_drain();

        // random: mostly valid operations on a shallow stack, some noise
        for (k = 0; k < 800; k++)
        begin
            if (k == 400)
                queue_drain();
            quiet_tail = (k >= 700);
            d = shadow_cnt[PLAN];
            roll = $urandom_range(0, 99);
            if (roll < 5)
                queue_cmd(mode_t'($urandom_range(0, 7)), $urandom, $urandom_range(0, 1023));
            else if ((roll < 40 && d < 48) || (d < 2 && roll < 85))
                queue_cmd(MODE_PUSH, pick_word(), 0);
            else if (roll < 50)
                queue_cmd(MODE_POP, 0, 0);
            else if (roll < 65)
            begin
                op = ($urandom_range(0, 1) == 0) ? MODE_PEEK_TOP : MODE_PEEK_BOT;
                if (d > 0 && $urandom_range(0, 3) != 0)
                    queue_cmd(op, 0, $urandom_range(0, d - 1));
                else
                    queue_cmd(op, 0, $urandom_range(0, 1023));
            end
            else
            begin
                op = mode_t'(MODE_ADD + $urandom_range(0, 3));
                if (op == MODE_DIV && d >= 1 && $urandom_range(0, 7) == 0)
                    queue_cmd(MODE_PUSH, 0, 0);
                queue_cmd(op, 0, 0);
            end
        end

        while (feed_q.size() != 0 || n_sent != n_got)
            @(posedge clk);
        repeat (60) @(posedge clk);

        if (expected_q.size() != 0)
        begin
            err_cnt++;
            $display("%0t: %0d expected results never arrived", $time, expected_q.size());
        end
        $display("summary: %0d commands, %0d results checked, deepest stack %0d",
                 n_sent, n_got, peak_depth);
        $display("summary: status counts ok %0d empty %0d range %0d few %0d full %0d div0 %0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5]);
        if (err_cnt == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #8_000_000;
        $display("%0t: run did not finish in time", $time);
        $display("tb: failure");
        $finish;
    end

endmodule
